// ===== rtl/core/lbbt_pkg.sv =====
// Shared types and codes for the per-label bounding box table.
// Used by the front, queue, back and top level; no dependencies.
package lbbt_pkg;

	// Operation codes on the input tuser
	localparam logic [1:0] OP_ACCUM  = 2'd0;
	localparam logic [1:0] OP_REPORT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Command kinds after classification
	localparam logic [1:0] KIND_ACCUM  = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_IMAGE_COLS = 2'd0;
	localparam logic [1:0] CFG_IMAGE_ROWS = 2'd1;
	localparam logic [1:0] CFG_LABEL_MAX  = 2'd2;
	localparam logic [1:0] CFG_MARGIN     = 2'd3;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] col;
		logic [11:0] row;
		logic [7:0]  label;
	} cmd_t;

	typedef struct packed {
		logic [12:0]        image_cols;
		logic [12:0]        image_rows;
		logic [7:0]         label_max;
		logic signed [13:0] margin;
	} cfg_t;

	typedef struct packed {
		logic [11:0] cmin;
		logic [11:0] cmax;
		logic [11:0] rmin;
		logic [11:0] rmax;
	} box_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  label;
		logic [12:0] col_lo;
		logic [12:0] row_lo;
		logic [12:0] width;
		logic [12:0] height;
	} res_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/core/lbbt_front.sv =====
// Front end: takes input transactions, drops unused codes, flags rejected labels.
// Depends on lbbt_pkg; feeds lbbt_queue.
module lbbt_front #(
	parameter int LABELS = 256
) (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic [7:0]        label_max,
	input  lbbt_pkg::qstat_t  qstat,
	output logic              push,
	output lbbt_pkg::cmd_t    push_cmd
);
	import lbbt_pkg::*;

	logic [7:0] label;
	logic       reject;
	logic       accept;
	logic [1:0] kind;

	assign label    = s_tdata[31:24];
	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;
	assign reject   = (label > label_max) || (32'(label) >= LABELS);

	always_comb begin
		case (s_tuser)
			OP_ACCUM:  kind = KIND_ACCUM;
			OP_REPORT: kind = KIND_REPORT;
			OP_CLEAR:  kind = KIND_CLEAR;
			default:   kind = KIND_ACCUM;
		endcase
		if (reject) begin
			kind = KIND_REJECT;
		end
	end

	// drop the unused operation code here, it never reaches the table
	assign push           = accept && (s_tuser != OP_UNUSED);
	assign push_cmd.kind  = kind;
	assign push_cmd.col   = s_tdata[11:0];
	assign push_cmd.row   = s_tdata[23:12];
	assign push_cmd.label = label;

endmodule

// ===== rtl/core/lbbt_queue.sv =====
// Short command queue decoupling the front end from the table engine.
// Depends on lbbt_pkg.
module lbbt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lbbt_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output lbbt_pkg::cmd_t    head,
	output lbbt_pkg::qstat_t  qstat
);
	import lbbt_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/lbbt_back.sv =====
// Table engine: read-modify-write of the box memory and box report with output register.
// Depends on lbbt_pkg; pops commands from lbbt_queue.
module lbbt_back #(
	parameter int LABELS  = 256,
	parameter int MAX_DIM = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lbbt_pkg::cfg_t    cfg,
	input  lbbt_pkg::qstat_t  qstat,
	input  lbbt_pkg::cmd_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output lbbt_pkg::res_t    out_res
);
	import lbbt_pkg::*;

	localparam int DEPTH = (LABELS < 256) ? LABELS : 256;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	box_t              mem [DEPTH];
	box_t              rd_q;
	logic [DEPTH-1:0]  valid_q;
	logic [1:0]        state_q;
	cmd_t              cmd_q;
	logic              hit_q;
	logic signed [15:0] clo_q, chi_q, rlo_q, rhi_q;
	logic              out_valid_q;
	res_t              out_q;

	logic [AW-1:0]     idx;
	logic              entry_valid;
	logic              mem_we;
	box_t              wr_box;
	logic [12:0]       col_lim, row_lim;
	logic signed [15:0] ms;
	logic signed [15:0] ca, cb, ra, rb;
	logic              out_free;
	logic              col_empty, row_empty;
	logic signed [15:0] cw, rh;

	assign idx         = cmd_q.label[AW-1:0];
	assign entry_valid = valid_q[idx];
	assign out_free    = !out_valid_q || out_ready;
	assign pop         = (state_q == ST_IDLE) && !qstat.empty;
	assign mem_we      = (state_q == ST_EXEC) && (cmd_q.kind == KIND_ACCUM);

	// widen the stored box to take in the pixel, or start a new one
	always_comb begin
		if (!entry_valid) begin
			wr_box.cmin = cmd_q.col;
			wr_box.cmax = cmd_q.col;
			wr_box.rmin = cmd_q.row;
			wr_box.rmax = cmd_q.row;
		end else begin
			wr_box.cmin = (cmd_q.col < rd_q.cmin) ? cmd_q.col : rd_q.cmin;
			wr_box.cmax = (cmd_q.col > rd_q.cmax) ? cmd_q.col : rd_q.cmax;
			wr_box.rmin = (cmd_q.row < rd_q.rmin) ? cmd_q.row : rd_q.rmin;
			wr_box.rmax = (cmd_q.row > rd_q.rmax) ? cmd_q.row : rd_q.rmax;
		end
	end

	// margin and clamp, first half of the report
	always_comb begin
		col_lim = (32'(cfg.image_cols) > MAX_DIM) ? 13'(MAX_DIM) : cfg.image_cols;
		row_lim = (32'(cfg.image_rows) > MAX_DIM) ? 13'(MAX_DIM) : cfg.image_rows;
		ms = {{2{cfg.margin[13]}}, cfg.margin};
		ca = $signed({4'b0, rd_q.cmin}) - ms;
		cb = $signed({4'b0, rd_q.cmax}) + 16'sd1 + ms;
		ra = $signed({4'b0, rd_q.rmin}) - ms;
		rb = $signed({4'b0, rd_q.rmax}) + 16'sd1 + ms;
		if (ca < 16'sd0) ca = 16'sd0;
		if (ra < 16'sd0) ra = 16'sd0;
		if (cb > $signed({3'b0, col_lim})) cb = $signed({3'b0, col_lim});
		if (rb > $signed({3'b0, row_lim})) rb = $signed({3'b0, row_lim});
	end

	assign col_empty = (clo_q >= chi_q);
	assign row_empty = (rlo_q >= rhi_q);
	assign cw        = chi_q - clo_q;
	assign rh        = rhi_q - rlo_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx] <= wr_box;
		end
		if (pop) begin
			rd_q <= mem[head.label[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == ST_EXEC) begin
			hit_q <= entry_valid;
			clo_q <= ca;
			chi_q <= cb;
			rlo_q <= ra;
			rhi_q <= rb;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q.status <= (cmd_q.kind == KIND_REJECT);
			out_q.label  <= cmd_q.label;
			if ((cmd_q.kind == KIND_REJECT) || !hit_q || col_empty || row_empty) begin
				out_q.col_lo <= '0;
				out_q.row_lo <= '0;
				out_q.width  <= '0;
				out_q.height <= '0;
			end else begin
				out_q.col_lo <= clo_q[12:0];
				out_q.row_lo <= rlo_q[12:0];
				out_q.width  <= cw[12:0];
				out_q.height <= rh[12:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.kind)
						KIND_ACCUM: begin
							valid_q[idx] <= 1'b1;
							state_q      <= ST_IDLE;
						end
						KIND_CLEAR: begin
							valid_q[idx] <= 1'b0;
							state_q      <= ST_IDLE;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== rtl/core/label_bounding_box_table_top.sv =====
// Top level of the per-label bounding box table: configuration registers and stream ports.
// Depends on lbbt_pkg, lbbt_front, lbbt_queue and lbbt_back.
//
// Keeps a bounding box per region label in a table that reset empties at once
// (one valid flip-flop per entry, no clearing pass). Each input transaction is
// classified by the front end and queued (four entries) for the table engine,
// which works on one command at a time: the registered memory read is followed
// by the update for accumulate and clear, or by the two report stages (margin
// and clamp, then width and height) for report and rejected-label results, plus
// any wait on m_tready. The front keeps taking transactions while the queue has
// room, and a finished result waits in the output register without blocking the
// queue. Operation code 3 is dropped without a result. Configuration must be
// written only while the block is idle, which the block itself does not enforce.
module label_bounding_box_table_top #(
	parameter int LABELS  = 256,
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_col[11:0], pixel_row[23:12], region_label[31:24]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // box_label[7:0], box_col_lo[20:8], box_row_lo[33:21],
	                               // box_width[46:34], box_height[59:47], zero fill
	output logic [0:0]  m_tuser    // status[0]
);
	import lbbt_pkg::*;

	cfg_t   cfg_q;
	qstat_t qstat;
	logic   push;
	cmd_t   push_cmd;
	logic   pop;
	cmd_t   head;
	res_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_cols <= 13'd4096;
			cfg_q.image_rows <= 13'd4096;
			cfg_q.label_max  <= 8'd255;
			cfg_q.margin     <= 14'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_COLS: cfg_q.image_cols <= cfg_data[12:0];
				CFG_IMAGE_ROWS: cfg_q.image_rows <= cfg_data[12:0];
				CFG_LABEL_MAX:  cfg_q.label_max  <= cfg_data[7:0];
				CFG_MARGIN:     cfg_q.margin     <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	lbbt_front #(
		.LABELS (LABELS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.label_max (cfg_q.label_max),
		.qstat     (qstat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	lbbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	lbbt_back #(
		.LABELS  (LABELS),
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {4'b0, res.height, res.width, res.row_lo, res.col_lo, res.label};
	assign m_tuser = res.status;

endmodule

// ===== sim/label_bounding_box_table_top_test.sv =====
// Self-checking test for label_bounding_box_table_top: directed and random streams of
// accumulate, report and clear transactions under several configurations.
// Depends on lbbt_pkg and the RTL of the block; predicts every result in place.
module label_bounding_box_table_top_test;
	import lbbt_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 32;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [13:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // pixel_col[11:0], pixel_row[23:12], region_label[31:24]
	logic [1:0]  s_tuser = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // box_label[7:0], box_col_lo[20:8], box_row_lo[33:21],
	                             // box_width[46:34], box_height[59:47], zero fill
	logic [0:0]  m_tuser;        // status[0]

	// Predicted box table and configuration
	bit          tbl_valid [256];
	logic [11:0] tbl_cmin [256];
	logic [11:0] tbl_cmax [256];
	logic [11:0] tbl_rmin [256];
	logic [11:0] tbl_rmax [256];
	logic [12:0] cur_cols;
	logic [12:0] cur_rows;
	logic [7:0]  cur_label_max;
	int          cur_margin;

	logic [11:0] anchor_col [256];
	logic [11:0] anchor_row [256];

	res_t due_results[$];
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   send_gaps = 1'b1;
	bit   recv_stalls = 1'b1;

	label_bounding_box_table_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= !recv_stalls || ($urandom_range(99) >= 20);
	end

	// Apply margin and clamp to one axis; returns 0 for an empty range
	function automatic bit clip_axis(input int mn, input int mx, input int lim,
	                                 output int lo, output int hi);
		lo = mn - cur_margin;
		hi = mx + 1 + cur_margin;
		if (lo < 0) lo = 0;
		if (hi > lim) hi = lim;
		return lo < hi;
	endfunction

	task automatic apply_to_box_table(input logic [1:0] op, input logic [11:0] col,
	                                  input logic [11:0] row, input logic [7:0] lab);
		res_t r;
		int   clo, chi, rlo, rhi, cl, rl;
		bit   c_ok, r_ok;
		if (op == OP_UNUSED) return;
		r = '0;
		r.label = lab;
		if (lab > cur_label_max) begin
			r.status = 1'b1;
			due_results.push_back(r);
			return;
		end
		case (op)
			OP_ACCUM: begin
				if (!tbl_valid[lab]) begin
					tbl_valid[lab] = 1'b1;
					tbl_cmin[lab] = col;
					tbl_cmax[lab] = col;
					tbl_rmin[lab] = row;
					tbl_rmax[lab] = row;
				end else begin
					if (col < tbl_cmin[lab]) tbl_cmin[lab] = col;
					if (col > tbl_cmax[lab]) tbl_cmax[lab] = col;
					if (row < tbl_rmin[lab]) tbl_rmin[lab] = row;
					if (row > tbl_rmax[lab]) tbl_rmax[lab] = row;
				end
			end
			OP_CLEAR: begin
				tbl_valid[lab] = 1'b0;
				tbl_cmin[lab] = '0;
				tbl_cmax[lab] = '0;
				tbl_rmin[lab] = '0;
				tbl_rmax[lab] = '0;
			end
			default: begin
				if (tbl_valid[lab]) begin
					cl = (cur_cols > 13'd4096) ? 4096 : int'(cur_cols);
					rl = (cur_rows > 13'd4096) ? 4096 : int'(cur_rows);
					c_ok = clip_axis(int'(tbl_cmin[lab]), int'(tbl_cmax[lab]), cl, clo, chi);
					r_ok = clip_axis(int'(tbl_rmin[lab]), int'(tbl_rmax[lab]), rl, rlo, rhi);
					if (c_ok && r_ok) begin
						r.col_lo = clo[12:0];
						r.row_lo = rlo[12:0];
						r.width  = 13'(chi - clo);
						r.height = 13'(rhi - rlo);
					end
				end
				due_results.push_back(r);
			end
		endcase
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_result
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual label %0h status %0b",
				         $time, m_tdata[7:0], m_tuser[0]);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("status", int'(want.status), int'(m_tuser[0]));
				check_field("box_label", int'(want.label), int'(m_tdata[7:0]));
				check_field("box_col_lo", int'(want.col_lo), int'(m_tdata[20:8]));
				check_field("box_row_lo", int'(want.row_lo), int'(m_tdata[33:21]));
				check_field("box_width", int'(want.width), int'(m_tdata[46:34]));
				check_field("box_height", int'(want.height), int'(m_tdata[59:47]));
				check_field("zero fill", 0, int'(m_tdata[63:60]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [11:0] col,
	                         input logic [11:0] row, input logic [7:0] lab);
		int gap;
		gap = (send_gaps && $urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {lab, row, col};
		do @(posedge clk); while (s_tready !== 1'b1);
		apply_to_box_table(op, col, row, lab);
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic hold_until_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// Also wait out accumulate and clear work still in the queue
	task automatic settle();
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_IMAGE_COLS: cur_cols = data[12:0];
			CFG_IMAGE_ROWS: cur_rows = data[12:0];
			CFG_LABEL_MAX:  cur_label_max = data[7:0];
			CFG_MARGIN:     cur_margin = int'($signed(data));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(input logic [12:0] cols, input logic [12:0] rows,
	                          input logic [7:0] lmax, input int marg);
		settle();
		write_reg(CFG_IMAGE_COLS, {1'b0, cols});
		write_reg(CFG_IMAGE_ROWS, {1'b0, rows});
		write_reg(CFG_LABEL_MAX, {6'd0, lmax});
		write_reg(CFG_MARGIN, marg[13:0]);
	endtask

	function automatic logic [11:0] pick_coord(input logic [11:0] anchor, input logic [12:0] lim);
		int          r;
		int          b;
		logic [11:0] v;
		r = $urandom_range(99);
		b = (lim > 13'd4095) ? 4095 : int'(lim);
		if (r < 45)
			v = anchor + 12'($urandom_range(0, 63));
		else if (r < 80)
			v = 12'($urandom_range(0, 4095));
		else begin
			case ($urandom_range(0, 3))
				0: v = 12'd0;
				1: v = 12'hFFF;
				2: v = 12'(b);
				default: v = (b > 0) ? 12'(b - 1) : 12'd0;
			endcase
		end
		return v;
	endfunction

	task automatic scatter_anchors();
		int cb, rb;
		cb = (cur_cols > 13'd4095) ? 4095 : int'(cur_cols);
		rb = (cur_rows > 13'd4095) ? 4095 : int'(cur_rows);
		for (int i = 0; i < 256; i++) begin
			anchor_col[i] = 12'($urandom_range(0, cb));
			anchor_row[i] = 12'($urandom_range(0, rb));
		end
	endtask

	// Mostly labels that are live and accepted, so boxes build up before reports
	task automatic send_random_item(output bit counted);
		int          r;
		logic [1:0]  op;
		logic [7:0]  lab;
		r = $urandom_range(99);
		if (r < 58) op = OP_ACCUM;
		else if (r < 85) op = OP_REPORT;
		else if (r < 96) op = OP_CLEAR;
		else op = OP_UNUSED;
		r = $urandom_range(99);
		if (r < 40)
			lab = (cur_label_max > 8'd7) ? 8'(cur_label_max - $urandom_range(0, 7))
			                             : 8'($urandom_range(0, 8));
		else if (r < 70)
			lab = 8'($urandom_range(0, 7));
		else
			lab = 8'($urandom_range(0, 255));
		send_item(op, pick_coord(anchor_col[lab], cur_cols),
		          pick_coord(anchor_row[lab], cur_rows), lab);
		counted = (op != OP_UNUSED);
	endtask

	task automatic send_random_run(input int n);
		int done;
		bit counted;
		done = 0;
		while (done < n) begin
			send_random_item(counted);
			if (counted) done++;
		end
	endtask

	task automatic test_directed();
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd0);
		send_item(OP_ACCUM, 12'd0, 12'd0, 8'd0);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd0);
		send_item(OP_ACCUM, 12'hFFF, 12'hFFF, 8'd0);
		send_item(OP_REPORT, 12'hFFF, 12'hFFF, 8'd0);
		send_item(OP_ACCUM, 12'd2048, 12'd1, 8'd255);
		send_item(OP_ACCUM, 12'd2047, 12'hFFF, 8'd255);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd255);
		send_item(OP_UNUSED, 12'hFFF, 12'hFFF, 8'd255);
		send_item(OP_CLEAR, 12'd0, 12'd0, 8'd0);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd0);
		send_item(OP_ACCUM, 12'hAAA, 12'h555, 8'hAA);
		send_item(OP_ACCUM, 12'h555, 12'hAAA, 8'h55);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'hAA);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'h55);
		// Every label above zero is rejected, for all operations but the unused code, which is dropped
		set_config(13'd4096, 13'd4096, 8'd0, 0);
		send_item(OP_ACCUM, 12'd5, 12'd5, 8'd1);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd1);
		send_item(OP_CLEAR, 12'd0, 12'd0, 8'hFF);
		send_item(OP_UNUSED, 12'd0, 12'd0, 8'd1);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd0);
		// Clamp to a small image; a pixel outside the image gives an empty box
		set_config(13'd100, 13'd50, 8'd255, 5);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd255);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'hAA);
		// Shrink a single pixel box until it inverts
		set_config(13'd4096, 13'd4096, 8'd255, -1);
		send_item(OP_ACCUM, 12'd10, 12'd10, 8'd7);
		send_item(OP_REPORT, 12'd0, 12'd0, 8'd7);
	endtask

	task automatic test_steady_stream();
		set_config(13'd640, 13'd480, 8'd200, 2);
		scatter_anchors();
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		send_random_run(300);
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
	endtask

	task automatic test_config_sweep();
		int marg;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_config(13'd4096, 13'd4096, 8'd255, 4096);
				1: set_config(13'd1, 13'd1, 8'd0, -4096);
				2: set_config(13'd0, 13'h1FFF, 8'd255, 8191);
				3: set_config(13'h1FFF, 13'd0, 8'd128, -8192);
				4: set_config(13'd64, 13'd48, 8'd15, -3);
				default: begin
					marg = ($urandom_range(1) == 1) ? $urandom_range(0, 80) - 40
					                                : int'($signed(14'($urandom_range(0, 16383))));
					set_config(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
					           8'($urandom_range(0, 255)), marg);
				end
			endcase
			scatter_anchors();
			send_random_run(200);
		end
	endtask

	task automatic test_sender_holdoff();
		set_config(13'd256, 13'd256, 8'd63, 1);
		scatter_anchors();
		for (int k = 0; k < 4; k++) begin
			send_random_run(25);
			hold_until_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_cmin[i] = '0;
			tbl_cmax[i] = '0;
			tbl_rmin[i] = '0;
			tbl_rmax[i] = '0;
		end
		cur_cols = 13'd4096;
		cur_rows = 13'd4096;
		cur_label_max = 8'd255;
		cur_margin = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_steady_stream();
		test_config_sweep();
		test_sender_holdoff();
		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
